FILE: sv/atlas_shelf_packer_macros.svh
// Assertion macros shared by the atlas shelf packer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ATLAS_SHELF_PACKER_MACROS_SVH
`define ATLAS_SHELF_PACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/asp_pkg.sv
// Shared types and constants of the atlas shelf packer.
// No dependencies; imported by the controller, datapath and top level.
package asp_pkg;

    localparam int RECT_W   = 10;
    localparam int GUTTER_W = 4;
    localparam int STATUS_W = 2;
    localparam int PAGE_O_W = 3;
    localparam int POS_W    = 11;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 32;

    localparam logic [GUTTER_W-1:0] GUTTER_RESET = 4'd2;

    localparam logic [STATUS_W-1:0] ST_PLACED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EVICTED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

    typedef struct packed {
        logic                load_in;
        logic                set_special;
        logic [STATUS_W-1:0] special_code;
        logic                eval_load;
        logic                open_load;
        logic                step;
        logic                write;
        logic                emit;
    } asp_cmd_t;

    typedef struct packed {
        logic zero_size;
        logic too_large;
        logic none_open;
        logic fit;
        logic last_page;
        logic out_free;
    } asp_sts_t;

endpackage

FILE: sv/asp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-page shelf state of the packer.
module asp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/asp_ctrl.sv
// Controller state machine of the atlas shelf packer.
// Depends on asp_pkg and atlas_shelf_packer_macros.svh; drives asp_datapath.
`include "atlas_shelf_packer_macros.svh"

module asp_ctrl
    import asp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  asp_sts_t sts,
    output asp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_OPEN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.zero_size)
                begin
                    cmd.set_special  = 1'b1;
                    cmd.special_code = ST_SKIPPED;
                    state_next       = S_DONE;
                end
                else if (sts.too_large)
                begin
                    cmd.set_special  = 1'b1;
                    cmd.special_code = ST_TOO_LARGE;
                    state_next       = S_DONE;
                end
                else if (sts.none_open)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                priority if (sts.fit)
                begin
                    cmd.eval_load = 1'b1;
                    state_next    = S_WRITE;
                end
                else if (sts.last_page)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_OPEN:
            begin
                cmd.open_load = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

    `ASP_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "result emitted over a full output")
    `ASP_ASSERT_IMP(a_step_bound, clk, rst_n, cmd.step, !sts.last_page, "scan stepped past the open pages")
    `ASP_ASSERT_NXT(a_place_write, clk, rst_n, cmd.eval_load || cmd.open_load, cmd.write, "placement not written back")

endmodule

FILE: sv/asp_datapath.sv
// Datapath of the atlas shelf packer: gutter register, page state memory,
// fit tests and the output register. Depends on asp_pkg and asp_ram.
module asp_datapath
    import asp_pkg::*;
#(
    parameter int ATLAS_EDGE = 2048,
    parameter int PAGE_LIMIT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GUTTER_W-1:0] cfg_wdata,
    input  logic [IN_W-1:0]     in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [OUT_W-1:0]    out_data,
    input  asp_cmd_t            cmd,
    output asp_sts_t            sts
);

    localparam int SW    = $clog2(ATLAS_EDGE + 4 * (1 << RECT_W) + 64);
    localparam int CXW   = $clog2(ATLAS_EDGE + 1);
    localparam int PW    = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
    localparam int CNTW  = $clog2(PAGE_LIMIT + 1);
    localparam int EW    = 2 * CXW + RECT_W;

    localparam logic [SW-1:0]   EDGE     = SW'(ATLAS_EDGE);
    localparam logic [CNTW-1:0] LIMIT    = CNTW'(PAGE_LIMIT);
    localparam logic [PW-1:0]   LAST_IDX = PW'(PAGE_LIMIT - 1);

    logic [GUTTER_W-1:0] gutter_reg;
    logic [RECT_W-1:0]   w_reg;
    logic [RECT_W-1:0]   h_reg;
    logic [PW-1:0]       idx_reg;
    logic [CNTW-1:0]     pages_open_reg;
    logic [PW-1:0]       oldest_reg;

    logic [STATUS_W-1:0] pl_status_reg;
    logic [PW-1:0]       pl_page_reg;
    logic [CXW-1:0]      pl_x_reg;
    logic [CXW-1:0]      pl_y_reg;
    logic [RECT_W-1:0]   pl_tall_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic [PW-1:0]       raddr;
    logic [EW-1:0]       rdata;
    logic [EW-1:0]       wdata;

    logic [SW-1:0]       w_ext;
    logic [SW-1:0]       h_ext;
    logic [SW-1:0]       g_ext;
    logic [SW-1:0]       cx;
    logic [SW-1:0]       cy;
    logic [RECT_W-1:0]   tl;
    logic [SW-1:0]       below;
    logic                fit_row;
    logic                fit_new;
    logic                has_room;

    logic [SW-1:0]       new_x;
    logic [RECT_W-1:0]   new_tall;
    logic [PW+2:0]       page_wide;
    logic [SW-1:0]       x_wide;
    logic [SW-1:0]       y_wide;

    assign w_ext = SW'(w_reg);
    assign h_ext = SW'(h_reg);
    assign g_ext = SW'(gutter_reg);

    assign cx    = SW'(rdata[CXW-1:0]);
    assign cy    = SW'(rdata[2*CXW-1:CXW]);
    assign tl    = rdata[EW-1:2*CXW];

    assign fit_row  = (cx + w_ext + g_ext <= EDGE) && (cy + h_ext + g_ext <= EDGE);
    assign below    = cy + SW'(tl) + g_ext;
    assign fit_new  = (below + h_ext + g_ext <= EDGE);
    assign has_room = (pages_open_reg < LIMIT);

    assign sts.zero_size = (w_reg == '0) || (h_reg == '0);
    assign sts.too_large = (w_ext + g_ext + g_ext > EDGE) || (h_ext + g_ext + g_ext > EDGE);
    assign sts.none_open = (pages_open_reg == '0);
    assign sts.fit       = fit_row || fit_new;
    assign sts.last_page = (CNTW'(idx_reg) + CNTW'(1) == pages_open_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign raddr    = cmd.step ? idx_reg + PW'(1) : idx_reg;
    assign new_x    = SW'(pl_x_reg) + w_ext + g_ext;
    assign new_tall = (h_reg > pl_tall_reg) ? h_reg : pl_tall_reg;
    assign wdata    = {new_tall, pl_y_reg, CXW'(new_x)};

    assign page_wide = {3'b000, pl_page_reg};
    assign x_wide    = SW'(pl_x_reg);
    assign y_wide    = SW'(pl_y_reg);

    asp_ram #(
        .WIDTH (EW),
        .DEPTH (PAGE_LIMIT)
    ) u_page_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (pl_page_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gutter_reg     <= GUTTER_RESET;
            idx_reg        <= '0;
            pages_open_reg <= '0;
            oldest_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gutter_reg <= cfg_wdata;
            end
            if (cmd.load_in)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + PW'(1);
            end
            if (cmd.open_load)
            begin
                if (has_room)
                begin
                    pages_open_reg <= pages_open_reg + CNTW'(1);
                end
                else
                begin
                    oldest_reg <= (oldest_reg == LAST_IDX) ? '0 : oldest_reg + PW'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            w_reg <= in_data[RECT_W-1:0];
            h_reg <= in_data[2*RECT_W-1:RECT_W];
        end
        priority if (cmd.set_special)
        begin
            pl_status_reg <= cmd.special_code;
            pl_page_reg   <= '0;
            pl_x_reg      <= '0;
            pl_y_reg      <= '0;
            pl_tall_reg   <= '0;
        end
        else if (cmd.eval_load)
        begin
            pl_status_reg <= ST_PLACED;
            pl_page_reg   <= idx_reg;
            pl_x_reg      <= fit_row ? CXW'(cx) : CXW'(g_ext);
            pl_y_reg      <= fit_row ? CXW'(cy) : CXW'(below);
            pl_tall_reg   <= fit_row ? tl : '0;
        end
        else if (cmd.open_load)
        begin
            pl_status_reg <= has_room ? ST_PLACED : ST_EVICTED;
            pl_page_reg   <= has_room ? pages_open_reg[PW-1:0] : oldest_reg;
            pl_x_reg      <= CXW'(g_ext);
            pl_y_reg      <= CXW'(g_ext);
            pl_tall_reg   <= '0;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {5'b00000, y_wide[POS_W-1:0], x_wide[POS_W-1:0],
                             page_wide[PAGE_O_W-1:0], pl_status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/atlas_shelf_packer.sv
// Top level of the atlas shelf packer: shelf allocator for glyph rectangles.
// Depends on asp_pkg, asp_ctrl, asp_datapath and asp_ram.

// The block places one glyph rectangle per item and returns one result item
// for it. An item passes CHECK, a scan of the open pages, a write-back and
// an output step; a zero-size or too-large glyph goes from CHECK straight to
// the output step, and a page is opened or evicted when no open page fits.
// The scan reads the page state memory, which yields one page per cycle
// through its single read port. A new item is taken while the previous
// result still waits in the output register.
module atlas_shelf_packer
    import asp_pkg::*;
#(
    parameter int ATLAS_EDGE = 2048,
    parameter int PAGE_LIMIT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GUTTER_W-1:0] cfg_wdata,    // gutter
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,      // rect_width, rect_height, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata       // status, page_index, pos_x, pos_y, zero pad
);

    asp_cmd_t cmd;
    asp_sts_t sts;

    asp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asp_datapath #(
        .ATLAS_EDGE (ATLAS_EDGE),
        .PAGE_LIMIT (PAGE_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
